[rtl/mcc_pkg.sv]
// Shared types and constants for the multiset containment checker.
// No dependencies; imported by multiset_containment_checker_top.
`default_nettype none

package mcc_pkg;

  localparam int SYM_W  = 8;
  localparam int CMD_W  = 2;
  localparam int PEND_W = 9;

  localparam logic [CMD_W-1:0] CMD_LETTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAGAZINE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SYM_W-1:0] symbol;
  } mcc_req_t;

  typedef struct packed {
    logic              constructible;
    logic [PEND_W-1:0] pending_kinds;
    logic              saturated;
  } mcc_rsp_t;

endpackage

`default_nettype wire

[rtl/multiset_containment_checker_top.sv]
// Each request passes through the s1 stage register and then the response register.
// Throughput: one request per cycle unless out_ready stalls; the count memory is read
// when a request is accepted and written when it leaves s1, with forwarding between.
// Reset (rst_n low, synchronous) clears all per-entry valid bits and the
// outstanding count at once; the block takes requests right after reset.
// Depends on mcc_pkg.
`default_nettype none

module multiset_containment_checker_top #(
  parameter int COUNT_BITS = 16,
  parameter int ALPHABET   = 256
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire mcc_pkg::mcc_req_t in_req,
  output logic                   out_valid,
  input  wire                    out_ready,
  output mcc_pkg::mcc_rsp_t      out_rsp
);
  import mcc_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [AW-1:0]    addr;
    logic             in_range;
  } s1_req_t;

  // count memory plus one valid bit per entry (invalid reads as zero)
  logic [COUNT_BITS-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0]   ent_vld_r;

  logic                  s1_vld_r;
  s1_req_t               s1_req_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  hit_r;
  logic                  fwd_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [PEND_W-1:0]     pend_r;
  logic [PEND_W-1:0]     pend_nxt;
  logic                  out_valid_r;
  mcc_rsp_t              out_rsp_r;

  logic                  accept;
  logic                  adv;
  logic                  in_range;
  logic [AW-1:0]         in_addr;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  we;
  logic                  sat;
  logic                  is_clr;

  assign in_range = {1'b0, in_req.symbol} < (SYM_W+1)'(ALPHABET);
  assign in_addr  = in_req.symbol[AW-1:0];
  assign adv      = s1_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign accept   = in_valid && in_ready;
  assign is_clr   = s1_req_r.cmd == CMD_CLEAR;

  // forwarded value covers a write or clear in the cycle of the read
  assign cur = fwd_r ? fwd_data_r : (hit_r ? rdata_r : '0);

  always_comb begin
    we       = 1'b0;
    sat      = 1'b0;
    new_cnt  = cur;
    pend_nxt = pend_r;
    if (is_clr) begin
      pend_nxt = '0;
    end else if (s1_req_r.in_range && s1_req_r.cmd == CMD_LETTER) begin
      if (cur == CNT_MAX) begin
        sat = 1'b1;
      end else begin
        we      = 1'b1;
        new_cnt = cur + COUNT_BITS'(1);
        if (cur == '0) begin
          pend_nxt = pend_r + PEND_W'(1);
        end
      end
    end else if (s1_req_r.in_range && s1_req_r.cmd == CMD_MAGAZINE && cur != '0) begin
      we      = 1'b1;
      new_cnt = cur - COUNT_BITS'(1);
      if (cur == COUNT_BITS'(1)) begin
        pend_nxt = pend_r - PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= mem[in_addr];
    end
    if (adv && we) begin
      mem[s1_req_r.addr] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r.cmd      <= in_req.cmd;
      s1_req_r.addr     <= in_addr;
      s1_req_r.in_range <= in_range;
      hit_r             <= ent_vld_r[in_addr];
      fwd_r             <= adv && (is_clr || (we && s1_req_r.addr == in_addr));
      fwd_data_r        <= is_clr ? '0 : new_cnt;
    end
    if (adv) begin
      out_rsp_r.constructible <= pend_nxt == '0;
      out_rsp_r.pending_kinds <= pend_nxt;
      out_rsp_r.saturated     <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      pend_r      <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        pend_r <= pend_nxt;
        if (is_clr) begin
          ent_vld_r <= '0;
        end else if (we) begin
          ent_vld_r[s1_req_r.addr] <= 1'b1;
        end
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(ALPHABET))
    else $error("outstanding count above alphabet size");

  a_constr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.constructible == (out_rsp_r.pending_kinds == '0)))
    else $error("constructible disagrees with pending_kinds");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_clr |=> pend_r == '0 && ent_vld_r == '0)
    else $error("clear left state behind");

  a_sat_letter: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_req_r.cmd != CMD_LETTER |=> !out_rsp_r.saturated)
    else $error("saturated flagged on non-letter request");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !adv)
    else $error("response overwritten while stalled");

endmodule

`default_nettype wire
